>>> hw/rtl/quaternion_slerp_defines.svh
// Assertion macros for the quaternion slerp RTL.
// Used by quaternion_slerp.sv; no other dependencies.
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH

`ifndef SYNTHESIS
`define QS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("quaternion_slerp: check failed");
`define QS_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("quaternion_slerp: forbidden condition seen");
`else
`define QS_ASSERT(name, prop)
`define QS_NEVER(name, expr)
`endif

`endif

>>> hw/rtl/qs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the CORDIC arctangent table for quaternion slerp.
// No dependencies.
package qs_pkg;

   localparam int FRAC_BITS          = 14;
   localparam int CORDIC_STAGES_DEF  = 16;
   localparam logic [14:0] ONE_Q     = 15'(1 << FRAC_BITS);
   localparam logic [14:0] THR_RESET = 15'd14746;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic [3:0][15:0] a;
      logic [3:0][16:0] b;
      logic [14:0]      t;
      logic             lin;
      logic [14:0]      dq;
      logic [14:0]      s;
   } side_type;

   // atan(2^-i) in Q30 radians
   function automatic logic signed [31:0] atan_q30(input int unsigned i);
      logic signed [31:0] r;
      case (i)
         0:  r = 32'sd843314857;
         1:  r = 32'sd497837829;
         2:  r = 32'sd263043837;
         3:  r = 32'sd133525159;
         4:  r = 32'sd67021687;
         5:  r = 32'sd33543516;
         6:  r = 32'sd16775851;
         7:  r = 32'sd8388437;
         8:  r = 32'sd4194283;
         9:  r = 32'sd2097149;
         10: r = 32'sd1048576;
         default: r = (i < 31) ? (32'sd1 <<< (30 - i)) : 32'sd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/quaternion_slerp.sv
`timescale 1ns / 1ps
// Quaternion slerp: fully pipelined dot product, square root, a vectoring and two rotating CORDICs and dividers.
// Depends on qs_pkg and quaternion_slerp_defines.svh.
`include "quaternion_slerp_defines.svh"

// Takes one request per cycle and returns one result per request, in order. The
// depth is set by the bit-per-stage square root and dividers and by the two
// CORDIC chains. The whole pipe holds while a result waits at the output.
// linear_threshold is written through csr_we/csr_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce.
module quaternion_slerp
   import qs_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend, zero pad (lowest first)
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r_x, r_y, r_z, r_w (lowest first)
   output logic [63:0]  rsp_tdata,
   // used_linear
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [14:0]  csr_wdata
);

   localparam int F      = FRAC_BITS;
   localparam int N      = CORDIC_STAGES;
   localparam int SQ     = F + 1;
   localparam int P_MUL  = 0;
   localparam int P_SUM  = 1;
   localparam int P_ABS  = 2;
   localparam int P_RAD  = 3;
   localparam int P_SQ0  = 4;
   localparam int P_VEC0 = P_SQ0 + SQ;
   localparam int P_KT   = P_VEC0 + N;
   localparam int P_ROT0 = P_KT + 1;
   localparam int P_PRE  = P_ROT0 + N;
   localparam int P_DIV0 = P_PRE + 1;
   localparam int P_WGT  = P_DIV0 + SQ;
   localparam int P_OUT  = P_WGT + 1;
   localparam int NSTG   = P_OUT + 1;
   localparam int SQW    = 2 * F + 3;
   localparam int VW     = F + 6;
   localparam int ZW     = 32;
   localparam int RW     = 34;
   localparam int DVW    = 18 + F;
   localparam logic [SQW-1:0] ONE2 = SQW'(1) << (2 * F);

   logic               en;
   logic [NSTG-1:0]    vld_ff;
   logic [14:0]        thr_ff;
   side_type           side_ff [P_WGT];

   logic signed [15:0] in_a [4];
   logic signed [15:0] in_b [4];
   logic [14:0]        in_blend;

   logic signed [31:0] prod_ff [4];
   logic signed [33:0] dot_ff;
   logic [SQW-1:0]     rad_ff;
   logic [SQW-1:0]     sq_rem_ff  [SQ];
   logic [F:0]         sq_root_ff [SQ];
   logic signed [VW-1:0] vx_ff [N];
   logic signed [VW-1:0] vy_ff [N];
   logic signed [ZW-1:0] vz_ff [N];
   logic signed [RW-1:0] kz_ff [2];
   logic signed [RW-1:0] rx_ff [2][N];
   logic signed [RW-1:0] ry_ff [2][N];
   logic signed [RW-1:0] rz_ff [2][N];
   logic [DVW-1:0]     dv_rem_ff [2][SQ+1];
   logic [F:0]         dv_q_ff   [2][SQ+1];
   logic               dv_ovf_ff [2][SQ+1];
   logic signed [31:0] pa_ff [4];
   logic signed [32:0] pb_ff [4];
   logic               lin_w_ff;
   logic [63:0]        rdata_ff;
   logic               rlin_ff;

   assign en         = !vld_ff[P_OUT] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[P_OUT];
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rlin_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         in_a[j] = req_tdata[16*j +: 16];
         in_b[j] = req_tdata[64 + 16*j +: 16];
      end
      in_blend = req_tdata[128 +: 15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   // ---- side data: operands and scalars that ride along with the request ----
   genvar k, l;
   generate
      for (k = 0; k < P_WGT; k++) begin : g_side
         side_type side_in;
         if (k == P_MUL) begin : g_first
            always_comb begin
               side_in = '0;
               for (int j = 0; j < 4; j++) begin
                  side_in.a[j] = in_a[j];
                  side_in.b[j] = 17'(in_b[j]);
               end
               side_in.t = (in_blend > ONE_Q) ? ONE_Q : in_blend;
            end
         end else if (k == P_ABS) begin : g_abs
            logic        neg;
            logic [33:0] absdot;
            logic [19:0] dqf;
            always_comb begin
               side_in = side_ff[k-1];
               neg     = dot_ff[33];
               absdot  = neg ? 34'(-dot_ff) : 34'(dot_ff);
               dqf     = absdot[33:F];
               for (int j = 0; j < 4; j++) begin
                  if (neg) begin
                     side_in.b[j] = 17'(-$signed(side_ff[k-1].b[j]));
                  end
               end
               side_in.lin = absdot > (34'(thr_ff) << F);
               side_in.dq  = (dqf >= 20'(ONE_Q)) ? ONE_Q : dqf[14:0];
            end
         end else if (k == P_VEC0) begin : g_sroot
            always_comb begin
               side_in   = side_ff[k-1];
               side_in.s = sq_root_ff[SQ-1];
            end
         end else begin : g_pass
            assign side_in = side_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k] <= side_in;
            end
         end
      end
   endgenerate

   // ---- dot product ----
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            prod_ff[j] <= in_a[j] * in_b[j];
         end
         dot_ff <= 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      end
   end

   // ---- 1 - dot^2 ----
   logic [29:0] dqsq;
   assign dqsq = side_ff[P_RAD-1].dq * side_ff[P_RAD-1].dq;
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= ONE2 - SQW'(dqsq);
      end
   end

   // ---- square root, one result bit per stage ----
   generate
      for (k = 0; k < SQ; k++) begin : g_sqrt
         localparam int BIT = F - k;
         logic [SQW-1:0] rin, trial;
         logic [F:0]     root_in;
         always_comb begin
            rin     = (k == 0) ? rad_ff : sq_rem_ff[(k == 0) ? 0 : k-1];
            root_in = (k == 0) ? '0 : sq_root_ff[(k == 0) ? 0 : k-1];
            trial   = (SQW'(root_in) << (BIT + 1)) | (SQW'(1) << (2 * BIT));
         end
         always_ff @(posedge clock) begin
            if (en) begin
               if (rin >= trial) begin
                  sq_rem_ff[k]  <= rin - trial;
                  sq_root_ff[k] <= root_in | ((F+1)'(1) << BIT);
               end else begin
                  sq_rem_ff[k]  <= rin;
                  sq_root_ff[k] <= root_in;
               end
            end
         end
      end
   endgenerate

   // ---- vectoring CORDIC: theta = atan2(s, dq) ----
   generate
      for (k = 0; k < N; k++) begin : g_vec
         logic signed [VW-1:0] xi, yi, dx, dy;
         logic signed [ZW-1:0] zi, at;
         always_comb begin
            if (k == 0) begin
               xi = VW'({1'b0, side_ff[P_VEC0-1].dq});
               yi = VW'({1'b0, sq_root_ff[SQ-1]});
               zi = '0;
            end else begin
               xi = vx_ff[(k == 0) ? 0 : k-1];
               yi = vy_ff[(k == 0) ? 0 : k-1];
               zi = vz_ff[(k == 0) ? 0 : k-1];
            end
            dx = yi >>> k;
            dy = xi >>> k;
            at = atan_q30(k);
         end
         always_ff @(posedge clock) begin
            if (en) begin
               if (!yi[VW-1]) begin
                  vx_ff[k] <= xi + dx;
                  vy_ff[k] <= yi - dy;
                  vz_ff[k] <= zi + at;
               end else begin
                  vx_ff[k] <= xi - dx;
                  vy_ff[k] <= yi + dy;
                  vz_ff[k] <= zi - at;
               end
            end
         end
      end
   endgenerate

   // ---- angles (1-t)*theta and t*theta ----
   logic signed [47:0] kt_prod [2];
   always_comb begin
      kt_prod[0] = $signed({1'b0, 15'(ONE_Q - side_ff[P_KT-1].t)}) * vz_ff[N-1];
      kt_prod[1] = $signed({1'b0, side_ff[P_KT-1].t}) * vz_ff[N-1];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         kz_ff[0] <= kt_prod[0][47:F];
         kz_ff[1] <= kt_prod[1][47:F];
      end
   end

   // ---- rotating CORDICs and dividers, one lane per weight ----
   generate
      for (l = 0; l < 2; l++) begin : g_lane
         for (k = 0; k < N; k++) begin : g_rot
            logic signed [RW-1:0] xi, yi, zi, dx, dy, at;
            always_comb begin
               if (k == 0) begin
                  xi = GAIN_Q30;
                  yi = '0;
                  zi = kz_ff[l];
               end else begin
                  xi = rx_ff[l][(k == 0) ? 0 : k-1];
                  yi = ry_ff[l][(k == 0) ? 0 : k-1];
                  zi = rz_ff[l][(k == 0) ? 0 : k-1];
               end
               dx = yi >>> k;
               dy = xi >>> k;
               at = RW'(atan_q30(k));
            end
            always_ff @(posedge clock) begin
               if (en) begin
                  if (!zi[RW-1]) begin
                     rx_ff[l][k] <= xi - dx;
                     ry_ff[l][k] <= yi + dy;
                     rz_ff[l][k] <= zi - at;
                  end else begin
                     rx_ff[l][k] <= xi + dx;
                     ry_ff[l][k] <= yi - dy;
                     rz_ff[l][k] <= zi + at;
                  end
               end
            end
         end

         // round the sine to Q14, drop negatives, flag quotients of two or more
         logic signed [RW:0] ys;
         logic signed [18:0] sn;
         logic [DVW-1:0]     dvd;
         always_comb begin
            ys  = (RW+1)'(ry_ff[l][N-1]) + (RW+1)'(1 << 15);
            sn  = 19'(ys >>> 16);
            dvd = sn[18] ? '0 : {sn[17:0], {F{1'b0}}};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               dv_rem_ff[l][0] <= dvd;
               dv_q_ff[l][0]   <= '0;
               dv_ovf_ff[l][0] <= dvd >= (DVW'(side_ff[P_PRE-1].s) << (F + 1));
            end
         end

         for (k = 1; k <= SQ; k++) begin : g_div
            localparam int BIT = SQ - k;
            logic [DVW-1:0] trial;
            assign trial = DVW'(side_ff[P_DIV0+k-2].s) << BIT;
            always_ff @(posedge clock) begin
               if (en) begin
                  dv_ovf_ff[l][k] <= dv_ovf_ff[l][k-1];
                  if (dv_rem_ff[l][k-1] >= trial) begin
                     dv_rem_ff[l][k] <= dv_rem_ff[l][k-1] - trial;
                     dv_q_ff[l][k]   <= dv_q_ff[l][k-1] | ((F+1)'(1) << BIT);
                  end else begin
                     dv_rem_ff[l][k] <= dv_rem_ff[l][k-1];
                     dv_q_ff[l][k]   <= dv_q_ff[l][k-1];
                  end
               end
            end
         end
      end
   endgenerate

   // ---- weight select and products ----
   side_type    sw;
   logic [14:0] wq [2];
   logic [14:0] u, v;
   logic        lim;
   always_comb begin
      sw = side_ff[P_WGT-1];
      for (int j = 0; j < 2; j++) begin
         wq[j] = (dv_ovf_ff[j][SQ] || dv_q_ff[j][SQ] > (F+1)'(ONE_Q)) ? ONE_Q
                 : dv_q_ff[j][SQ][14:0];
      end
      lim = sw.lin || (sw.s == '0);
      u   = lim ? 15'(ONE_Q - sw.t) : wq[0];
      v   = lim ? sw.t : wq[1];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            pa_ff[j] <= $signed(sw.a[j]) * $signed({1'b0, u});
            pb_ff[j] <= $signed(sw.b[j]) * $signed({1'b0, v});
         end
         lin_w_ff <= sw.lin;
      end
   end

   // ---- round, saturate, hold for the consumer ----
   logic signed [33:0] acc [4];
   logic signed [19:0] rr  [4];
   logic [63:0]        rnext;
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc[j] = 34'(pa_ff[j]) + 34'(pb_ff[j]) + 34'sd8192;
         rr[j]  = 20'(acc[j] >>> F);
         if (rr[j] > 20'sd32767) begin
            rnext[16*j +: 16] = 16'h7fff;
         end else if (rr[j] < -20'sd32768) begin
            rnext[16*j +: 16] = 16'h8000;
         end else begin
            rnext[16*j +: 16] = rr[j][15:0];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= rnext;
         rlin_ff  <= lin_w_ff;
      end
   end

   // a live quotient that fit in range leaves a remainder below the divisor
   logic div_live;
   assign div_live = vld_ff[P_WGT-1] && !dv_ovf_ff[0][SQ] && (sw.s != '0);

   `QS_ASSERT(a_accept_enters, (req_tvalid && req_tready) |=> vld_ff[P_MUL])
   `QS_NEVER(a_sqrt_rem, vld_ff[P_VEC0-1] && (sq_rem_ff[SQ-1] > (SQW'(sq_root_ff[SQ-1]) << 1)))
   `QS_ASSERT(a_div_rem, div_live |-> (dv_rem_ff[0][SQ] < DVW'(sw.s)))

endmodule
